@@ rtl/onb_pkg.sv @@
package onb_pkg;

    localparam int DIR_W = 16;
    localparam int OUT_W = 18;

    typedef struct packed {
        logic signed [DIR_W-1:0] light_x;
        logic signed [DIR_W-1:0] light_y;
        logic signed [DIR_W-1:0] light_z;
        logic signed [DIR_W-1:0] view_x;
        logic signed [DIR_W-1:0] view_y;
        logic signed [DIR_W-1:0] view_z;
    } onb_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] refl_red;
        logic [OUT_W-1:0] refl_green;
        logic [OUT_W-1:0] refl_blue;
    } onb_out_t;

    localparam logic [1:0] REG_ROUGHNESS = 2'd0;
    localparam logic [1:0] REG_ALB_RED   = 2'd1;
    localparam logic [1:0] REG_ALB_GREEN = 2'd2;
    localparam logic [1:0] REG_ALB_BLUE  = 2'd3;

    localparam logic [31:0] K_033    = 32'd5536481;
    localparam logic [31:0] K_009    = 32'd1509949;
    localparam logic [15:0] K_HALF   = 16'd32768;
    localparam logic [15:0] K_045    = 16'd29491;
    localparam logic [15:0] K_INV_PI = 16'd20861;

endpackage

@@ rtl/onb_divider.sv @@
module onb_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quo = q_reg[Q_W-1:0];
endmodule

@@ rtl/oren_nayar_brdf_eval_core.sv @@
// Accepts one item per cycle while busy is low.
// Pipeline: input stage, sine square roots over 16 stages, clamp stage, G divide over
// 11 stages (3 quotient bits each), then B*G, inner, albedo and 1/pi stages.
// The result receiver cannot stall; busy is low except after a roughness
// write while A and B derive - caller writes config only when the pipeline is empty.
// Reset: asynchronous active-low; coef_a = 1.0, coef_b = 0, albedos zero.
module oren_nayar_brdf_eval_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  onb_pkg::onb_in_t  in_item,
    output logic              result_valid,
    output onb_pkg::onb_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import onb_pkg::*;

    localparam int F = 15;
    localparam int SQ_ST = 16;

    // ---------------- configuration ----------------
    logic [15:0] alb_reg [3];
    logic [16:0] coef_a_reg;
    logic [15:0] coef_b_reg;
    logic [31:0] s2_reg;
    logic [1:0]  dphase_reg;
    logic        div_load;
    logic [47:0] div_num;
    logic [32:0] div_den;
    logic        div_done;
    logic [16:0] div_q;
    logic [31:0] rsq;

    assign cfg_ready = (dphase_reg == 2'd0);
    assign rsq = 32'(cfg_data) * 32'(cfg_data);

    always_comb
    begin
        div_load = 1'b0;
        div_num  = '0;
        div_den  = '0;
        if (dphase_reg == 2'd1)
        begin
            div_load = 1'b1;
            div_num  = 48'(s2_reg) * 48'(K_HALF) + 48'(({1'b0, s2_reg} + 33'(K_033)) >> 1);
            div_den  = {1'b0, s2_reg} + 33'(K_033);
        end
        else if (dphase_reg == 2'd2 && div_done)
        begin
            div_load = 1'b1;
            div_num  = 48'(s2_reg) * 48'(K_045) + 48'(({1'b0, s2_reg} + 33'(K_009)) >> 1);
            div_den  = {1'b0, s2_reg} + 33'(K_009);
        end
    end

    onb_divider #(.NUM_W(48), .DEN_W(33), .Q_W(17)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .load (div_load),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dphase_reg <= 2'd0;
            coef_a_reg <= 17'h10000;
            coef_b_reg <= '0;
            alb_reg[0] <= '0;
            alb_reg[1] <= '0;
            alb_reg[2] <= '0;
            s2_reg     <= '0;
        end
        else
        begin
            case (dphase_reg)
                2'd0:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_ROUGHNESS:
                            begin
                                s2_reg     <= rsq;
                                dphase_reg <= 2'd1;
                            end
                            REG_ALB_RED:   alb_reg[0] <= cfg_data;
                            REG_ALB_GREEN: alb_reg[1] <= cfg_data;
                            REG_ALB_BLUE:  alb_reg[2] <= cfg_data;
                            default: ;
                        endcase
                    end
                end
                2'd1: dphase_reg <= 2'd2;
                2'd2:
                begin
                    if (div_done)
                    begin
                        coef_a_reg <= 17'h10000 - div_q;
                        dphase_reg <= 2'd3;
                    end
                end
                default:
                begin
                    if (div_done)
                    begin
                        coef_b_reg <= div_q[15:0];
                        dphase_reg <= 2'd0;
                    end
                end
            endcase
        end
    end

    assign busy = (dphase_reg != 2'd0);

    wire accept = start && !busy;

    // ---------------- stage 0: cosines, dot, flags ----------------
    logic        v0_reg;
    logic [15:0] cl0_reg, cv0_reg;
    logic [31:0] dot0_reg;
    logic        zero0_reg, near0_reg;

    logic [15:0] cl_c, cv_c;
    logic signed [31:0] px_c, py_c;
    logic signed [32:0] dot_c;
    assign cl_c = in_item.light_z[15] ? 16'(-in_item.light_z) : 16'(in_item.light_z);
    assign cv_c = in_item.view_z[15] ? 16'(-in_item.view_z) : 16'(in_item.view_z);
    assign px_c = in_item.light_x * in_item.view_x;
    assign py_c = in_item.light_y * in_item.view_y;
    assign dot_c = 33'(px_c) + 33'(py_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        cl0_reg   <= cl_c;
        cv0_reg   <= cv_c;
        dot0_reg  <= (dot_c > 0) ? dot_c[31:0] : '0;
        zero0_reg <= (cl_c == 0) || (cv_c == 0);
        near0_reg <= (23'(cl_c) * 23'd100 >= 23'(99 << F)) ||
                     (23'(cv_c) * 23'd100 >= 23'(99 << F));
    end

    // ---------------- stages 1..16: two square roots ----------------
    typedef struct packed {
        logic        v;
        logic [31:0] nl, nv;
        logic [15:0] rl, rv;
        logic [15:0] cl, cv;
        logic [31:0] dot;
        logic        zero, near;
    } sq_t;

    sq_t sq_reg [SQ_ST+1];

    function automatic logic [47:0] sqstep(input logic [31:0] n, input logic [15:0] r,
                                           input int i);
        logic [31:0] b;
        logic [31:0] t;
        b = 32'(1) << (2 * (15 - i));
        t = (32'(r) << (16 - i)) | b;
        if (n >= t)
            sqstep = {n - t, r | 16'(16'h1 << (15 - i))};
        else
            sqstep = {n, r};
    endfunction

    always_comb
    begin
        sq_reg[0].v    = v0_reg;
        sq_reg[0].nl   = 32'(1 << (2 * F)) - 32'(cl0_reg) * 32'(cl0_reg);
        sq_reg[0].nv   = 32'(1 << (2 * F)) - 32'(cv0_reg) * 32'(cv0_reg);
        sq_reg[0].rl   = '0;
        sq_reg[0].rv   = '0;
        sq_reg[0].cl   = cl0_reg;
        sq_reg[0].cv   = cv0_reg;
        sq_reg[0].dot  = dot0_reg;
        sq_reg[0].zero = zero0_reg;
        sq_reg[0].near = near0_reg;
    end

    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_sq
        logic [47:0] sl, sv;
        assign sl = sqstep(sq_reg[g].nl, sq_reg[g].rl, g);
        assign sv = sqstep(sq_reg[g].nv, sq_reg[g].rv, g);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[g+1] <= '0;
            else
            begin
                sq_reg[g+1].v    <= sq_reg[g].v;
                sq_reg[g+1].nl   <= sl[47:16];
                sq_reg[g+1].rl   <= sl[15:0];
                sq_reg[g+1].nv   <= sv[47:16];
                sq_reg[g+1].rv   <= sv[15:0];
                sq_reg[g+1].cl   <= sq_reg[g].cl;
                sq_reg[g+1].cv   <= sq_reg[g].cv;
                sq_reg[g+1].dot  <= sq_reg[g].dot;
                sq_reg[g+1].zero <= sq_reg[g].zero;
                sq_reg[g+1].near <= sq_reg[g].near;
            end
        end
    end

    // ---------------- stage A: clamp dot, pick max cosine ----------------
    logic        va_reg, zeroa_reg, neara_reg;
    logic [31:0] cda_reg;
    logic [15:0] cma_reg;
    logic [31:0] ss_c;
    assign ss_c = 32'(sq_reg[SQ_ST].rl) * 32'(sq_reg[SQ_ST].rv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= sq_reg[SQ_ST].v;
    end

    always_ff @(posedge clk)
    begin
        cda_reg   <= (sq_reg[SQ_ST].dot < ss_c) ? sq_reg[SQ_ST].dot : ss_c;
        cma_reg   <= (sq_reg[SQ_ST].cl > sq_reg[SQ_ST].cv) ? sq_reg[SQ_ST].cl
                                                             : sq_reg[SQ_ST].cv;
        zeroa_reg <= sq_reg[SQ_ST].zero;
        neara_reg <= sq_reg[SQ_ST].near;
    end

    // ---------------- G divide: (cd<<1)/cm, 33-bit quotient, radix-2 over 11 stages -----
    localparam int QW = 33;
    localparam int DST = 11;
    localparam int BPS = 3;

    typedef struct packed {
        logic        v, zero, near;
        logic [32:0] num;
        logic [16:0] rem;
        logic [15:0] den;
        logic [32:0] q;
    } dv_t;

    dv_t dv_reg [DST+1];

    always_comb
    begin
        dv_reg[0].v    = va_reg;
        dv_reg[0].zero = zeroa_reg;
        dv_reg[0].near = neara_reg;
        dv_reg[0].num  = {cda_reg, 1'b0};
        dv_reg[0].rem  = '0;
        dv_reg[0].den  = (cma_reg == 0) ? 16'd1 : cma_reg;
        dv_reg[0].q    = '0;
    end

    for (genvar s = 0; s < DST; s++)
    begin : g_dv
        dv_t nx;
        always_comb
        begin
            logic [17:0] t;
            nx = dv_reg[s];
            for (int k = 0; k < BPS; k++)
            begin
                if (s * BPS + k < QW)
                begin
                    t = {nx.rem, nx.num[QW-1]};
                    nx.num = nx.num << 1;
                    if (t >= {2'b0, nx.den})
                    begin
                        nx.rem = 17'(t - {2'b0, nx.den});
                        nx.q   = {nx.q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        nx.rem = t[16:0];
                        nx.q   = {nx.q[QW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s+1] <= '0;
            else
                dv_reg[s+1] <= nx;
        end
    end

    // ---------------- stage B: B*G ----------------
    logic        vb_reg, zerob_reg, nearb_reg;
    logic [48:0] bg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= dv_reg[DST].v;
    end
    always_ff @(posedge clk)
    begin
        bg_reg    <= 49'(coef_b_reg) * 49'(dv_reg[DST].q);
        zerob_reg <= dv_reg[DST].zero;
        nearb_reg <= dv_reg[DST].near;
    end

    // ---------------- stage C: inner = A + B*G, or A alone when near ----------------
    logic        vc_reg, zeroc_reg;
    logic [44:0] inner_reg;
    logic [41:0] sum_c;
    assign sum_c = 42'({coef_a_reg, 8'h0}) + 42'(bg_reg >> 8);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        zeroc_reg <= zerob_reg;
        if (nearb_reg)
            inner_reg <= 45'({coef_a_reg, 8'h0});
        else
            inner_reg <= 45'(sum_c);
    end

    // ---------------- stage D: times albedo ----------------
    logic        vd_reg, zerod_reg;
    logic [44:0] t_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else
            vd_reg <= vc_reg;
    end
    for (genvar c = 0; c < 3; c++)
    begin : g_alb
        logic [60:0] p;
        assign p = 61'(inner_reg) * 61'(alb_reg[c]);
        always_ff @(posedge clk)
            t_reg[c] <= p[60:16];
    end
    always_ff @(posedge clk)
        zerod_reg <= zeroc_reg;

    // ---------------- stage E: 1/pi, saturate ----------------
    onb_out_t res_reg;
    logic     ve_reg;
    logic [OUT_W-1:0] chan [3];
    for (genvar c = 0; c < 3; c++)
    begin : g_pi
        logic [60:0] r;
        assign r = (61'(t_reg[c]) * 61'(K_INV_PI)) >> 24;
        assign chan[c] = zerod_reg ? '0 :
                         (r > 61'((1 << OUT_W) - 1)) ? OUT_W'((1 << OUT_W) - 1)
                                                     : r[OUT_W-1:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else
            ve_reg <= vd_reg;
    end
    always_ff @(posedge clk)
    begin
        res_reg.refl_red   <= chan[0];
        res_reg.refl_green <= chan[1];
        res_reg.refl_blue  <= chan[2];
    end

    assign result_valid = ve_reg;
    assign result       = res_reg;

    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready) else $error("cfg ready while busy");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        sq_reg[SQ_ST].v |-> ##(DST+5) result_valid) else $error("lost item");
    a_dphase: assert property (@(posedge clk) disable iff (!rst_n)
        (dphase_reg == 2'd1) |=> (dphase_reg == 2'd2)) else $error("derive seq");
endmodule

@@ tb/oren_nayar_brdf_eval_core_tb.sv @@
`timescale 1ns / 100ps

module oren_nayar_brdf_eval_core_tb;
    import onb_pkg::*;

    localparam int LATENCY = 32;
    localparam int ONE_DIR = 32768;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    onb_in_t  in_item;
    logic     result_valid;
    onb_out_t result;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    logic [15:0] rough_q;
    logic [15:0] alb_q [3];
    logic [16:0] coef_a_q;
    logic [15:0] coef_b_q;

    onb_out_t refl_expected [$];
    int mismatches;
    int unexpected;

    oren_nayar_brdf_eval_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void derive_coefs();
        longint unsigned s2;
        longint unsigned d;
        longint unsigned e;
        s2 = longint'(rough_q) * longint'(rough_q);
        d = s2 + K_033;
        e = s2 + K_009;
        coef_a_q = 17'(65536 - (s2 * K_HALF + d / 2) / d);
        coef_b_q = 16'((s2 * K_045 + e / 2) / e);
    endfunction

    function automatic onb_out_t predict_refl(onb_in_t it);
        longint signed lx, ly, vx, vy, dot;
        longint unsigned cl, cv, inner, sl, sv, ss, cd, cm, g16, t, r;
        logic [OUT_W-1:0] ch [3];
        onb_out_t o;
        lx = it.light_x; ly = it.light_y; vx = it.view_x; vy = it.view_y;
        cl = (it.light_z < 0) ? -longint'(it.light_z) : longint'(it.light_z);
        cv = (it.view_z < 0) ? -longint'(it.view_z) : longint'(it.view_z);
        if (cl == 0 || cv == 0)
            return '0;
        if (cl * 100 >= 99 * ONE_DIR || cv * 100 >= 99 * ONE_DIR)
            inner = longint'(coef_a_q) << 8;
        else
        begin
            sl = int_sqrt(longint'(ONE_DIR) * ONE_DIR - cl * cl);
            sv = int_sqrt(longint'(ONE_DIR) * ONE_DIR - cv * cv);
            ss = sl * sv;
            dot = lx * vx + ly * vy;
            cd = 0;
            if (dot > 0)
                cd = (longint'(dot) < ss) ? dot : ss;
            cm = (cl > cv) ? cl : cv;
            g16 = (cd << 1) / cm;
            inner = (longint'(coef_a_q) << 8) + ((longint'(coef_b_q) * g16) >> 8);
            if (inner > (64'd1 << 44))
                inner = 64'd1 << 44;
        end
        for (int k = 0; k < 3; k++)
        begin
            t = (inner * alb_q[k]) >> 16;
            r = (t * K_INV_PI) >> 24;
            ch[k] = (r > 262143) ? 18'h3ffff : r[17:0];
        end
        o.refl_red = ch[0];
        o.refl_green = ch[1];
        o.refl_blue = ch[2];
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        onb_out_t exp_r;
        if (rst_n && result_valid)
        begin
            if (refl_expected.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result %h at %0t", result, $realtime);
            end
            else
            begin
                exp_r = refl_expected.pop_front();
                if (exp_r.refl_red !== result.refl_red
                    || exp_r.refl_green !== result.refl_green
                    || exp_r.refl_blue !== result.refl_blue)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                            exp_r.refl_red, exp_r.refl_green, exp_r.refl_blue,
                            result.refl_red, result.refl_green, result.refl_blue);
                end
            end
        end
    end

    // start stays high across back-to-back items and drops only when a gap begins
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n != 0)
            start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_dir(onb_in_t it);
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        refl_expected.push_back(predict_refl(it));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (refl_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ROUGHNESS)
        begin
            rough_q = val;
            derive_coefs();
        end
        else
            alb_q[idx - 1] = val;
        @(negedge clk);
    endtask

    task automatic set_material(logic [15:0] r, logic [15:0] a0, logic [15:0] a1,
                                logic [15:0] a2);
        write_reg(REG_ROUGHNESS, r);
        write_reg(REG_ALB_RED, a0);
        write_reg(REG_ALB_GREEN, a1);
        write_reg(REG_ALB_BLUE, a2);
        cfg_valid <= 1'b0;
    endtask

    function automatic onb_in_t mk_dir(int lx, int ly, int lz, int vx, int vy, int vz);
        onb_in_t it;
        it.light_x = 16'(lx); it.light_y = 16'(ly); it.light_z = 16'(lz);
        it.view_x = 16'(vx); it.view_y = 16'(vy); it.view_z = 16'(vz);
        return it;
    endfunction

    // two roughly unit vectors with random azimuth-like components
    function automatic onb_in_t unit_pair();
        onb_in_t it;
        int z, s, x;
        logic [15:0] f [6];
        for (int k = 0; k < 2; k++)
        begin
            z = $urandom_range(1, 32767);
            s = int'(int_sqrt(64'd1073741824 - longint'(z) * z));
            x = $urandom_range(0, s);
            f[k*3] = $urandom_range(0, 1) ? 16'(-x) : 16'(x);
            f[k*3+1] = 16'(int_sqrt(longint'(s) * s - longint'(x) * x));
            if ($urandom_range(0, 1)) f[k*3+1] = -f[k*3+1];
            f[k*3+2] = $urandom_range(0, 1) ? 16'(-z) : 16'(z);
        end
        it = {f[0], f[1], f[2], f[3], f[4], f[5]};
        return it;
    endfunction

    task automatic test_directed();
        set_material(16'd0, 16'hffff, 16'h8000, 16'h0000);
        send_dir(mk_dir(0, 0, 32767, 0, 0, 32767));
        send_dir(mk_dir(100, 0, 0, 0, 0, 20000));          // grazing light
        send_dir(mk_dir(0, 0, 20000, 100, 0, 0));          // grazing view
        send_dir(mk_dir(0, 0, -32768, 0, 0, -32768));      // cosine of one
        send_dir(mk_dir(0, 0, 32441, 20000, 0, 10000));    // first cosine at 0.99
        send_dir(mk_dir(0, 0, 32440, 20000, 0, 10000));    // just below 0.99
        wait_drained();
        set_material(16'hffff, 16'hffff, 16'hffff, 16'h0001);
        send_dir(mk_dir(23170, 0, 23170, 23170, 0, 23170));
        send_dir(mk_dir(32767, 32767, 1, 32767, 32767, 1)); // non-unit, huge G
        send_dir(mk_dir(-32768, -32768, 1, -32768, -32768, -1));
        send_dir(mk_dir(-32768, 32767, 100, 32767, -32768, 100)); // negative dot
        send_dir(mk_dir(32767, -32768, -32768, 0, 32767, 32767));
        wait_drained();
        set_material(16'd2145, 16'd40000, 16'd1, 16'hffff);
        send_dir(mk_dir(20000, 10000, 20000, 15000, 12000, 22000));
        send_dir(mk_dir(-20000, 5000, -20000, -15000, 8000, 22000));
        send_dir(mk_dir(1, 1, 1, 1, 1, 1));
        send_dir(mk_dir(-1, -1, -1, -1, -1, -1));
        wait_drained();
    endtask

    task automatic test_random_phase(int n_items);
        onb_in_t it;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                it = {$urandom(), $urandom(), $urandom()};
            else
                it = unit_pair();
            send_dir(it);
            random_gap();
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_material(16'hffff, 16'hffff, 16'hffff, 16'hffff);
                1: set_material(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: set_material(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                      16'($urandom()));
            endcase
            test_random_phase(270);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROUGHNESS;
        cfg_data = '0;
        mismatches = 0;
        unexpected = 0;
        rough_q = '0;
        alb_q[0] = '0; alb_q[1] = '0; alb_q[2] = '0;
        coef_a_q = 17'd65536;
        coef_b_q = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        wait_drained();
        if (mismatches == 0 && unexpected == 0 && refl_expected.size() == 0)
            $display("** oren_nayar_brdf_eval_core: PASSED **");
        else
            $display("** oren_nayar_brdf_eval_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** oren_nayar_brdf_eval_core: FAILED **");
        $finish;
    end

endmodule
